FILE: design/lsd_pkg.sv
// Shared constants and helpers for the LFSR stream decryptor.
package lsd_pkg;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned BYTE_W     = 8;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [BYTE_W-1:0]     byte_t;

  localparam cfg_idx_t REG_TAP_MASK      = cfg_idx_t'(0);
  localparam cfg_idx_t REG_INITIAL_STATE = cfg_idx_t'(1);

  localparam byte_t CHAR_SPACE = 8'h20;
  localparam byte_t CHAR_DEL_END = 8'h80;
  localparam byte_t CHAR_CR    = 8'h0D;
  localparam byte_t CHAR_LF    = 8'h0A;
  localparam byte_t CHAR_NUL   = 8'h00;

  // Printable means 0x20..0x7F, carriage return, line feed or NUL.
  function automatic logic is_printable(input byte_t c);
    logic ok;
    ok = ((c >= CHAR_SPACE) && (c < CHAR_DEL_END)) ||
         (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_NUL);
    return ok;
  endfunction

endpackage

FILE: design/lsd_jump_gen.sv
// Builds the affine WIDTH-shift jump map of the LFSR from the tap mask.
module lsd_jump_gen #(
  parameter int unsigned WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [WIDTH-1:0]             tap,
  output logic [WIDTH-1:0][WIDTH-1:0]  jump_coef,
  output logic [WIDTH-1:0]             jump_cst,
  output logic                         busy
);
  import lsd_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

  // Row k holds the coefficients of register bit k over the starting state.
  logic [WIDTH-1:0][WIDTH-1:0] coef_r, coef_nxt;
  logic [WIDTH-1:0]            cst_r, cst_nxt;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic [WIDTH-1:0]            fb_coef;
  logic [WIDTH-1:0]            col;
  logic                        fb_cst;

  // One LFSR step applied symbolically: feedback = parity(tap & r) ^ parity(tap).
  always_comb begin
    col = '0;
    for (int c = 0; c < WIDTH; c++) begin
      for (int j = 0; j < WIDTH; j++) begin
        col[j] = tap[j] & coef_r[j][c];
      end
      fb_coef[c] = ^col;
    end
    fb_cst = (^tap) ^ (^(tap & cst_r));
    for (int k = 0; k < WIDTH - 1; k++) begin
      coef_nxt[k] = coef_r[k+1];
    end
    coef_nxt[WIDTH-1] = fb_coef;
    cst_nxt = {fb_cst, cst_r[WIDTH-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      for (int k = 0; k < WIDTH; k++) begin
        coef_r[k] <= {{(WIDTH-1){1'b0}}, 1'b1} << k;
      end
      cst_r <= '0;
    end else if (busy_r) begin
      coef_r <= coef_nxt;
      cst_r  <= cst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign jump_coef = coef_r;
  assign jump_cst  = cst_r;
  assign busy      = busy_r;

endmodule

FILE: design/lfsr_stream_decrypt.sv
// Top level of the LFSR stream decryptor: config registers, jump apply, output skid.
// An accepted item's result is registered into the output register, or into the skid entry if that is held.
// Throughput: one item per cycle while in_stall is low; the whole WIDTH-shift advance is one registered step.
// After reset and each tap_mask write, in_stall stays high while the jump map is rebuilt.
// Reset (synchronous, active low) clears taps, initial state and the shift register to
// zero, sets the message flag and empties the output stage.
module lfsr_stream_decrypt #(
  parameter int unsigned WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input item channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  lsd_pkg::byte_t      in_cipher_byte,
  input  logic                in_restart_message,
  // Result item channel.
  output logic                out_valid,
  input  logic                out_stall,
  output lsd_pkg::byte_t      out_plain_byte,
  output logic                out_byte_printable,
  output logic                out_message_printable,
  // Configuration write port.
  input  logic                cfg_we,
  input  lsd_pkg::cfg_idx_t   cfg_index,
  input  lsd_pkg::cfg_data_t  cfg_wdata
);
  import lsd_pkg::*;

  // Configuration registers; only the low WIDTH bits matter.
  logic [WIDTH-1:0] tap_mask_r;
  logic [WIDTH-1:0] init_state_r;
  logic             tap_wr;

  assign tap_wr = cfg_we && (cfg_index == REG_TAP_MASK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_mask_r   <= '0;
      init_state_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAP_MASK:      tap_mask_r   <= cfg_wdata[WIDTH-1:0];
        REG_INITIAL_STATE: init_state_r <= cfg_wdata[WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // The WIDTH shifts taken per item form an affine map over GF(2):
  // next_state = COEF * state ^ CST. The map depends only on the taps, so it is
  // rebuilt after reset and on every tap write, then applied to every item as one combinational step.
  logic [WIDTH-1:0][WIDTH-1:0] jump_coef;
  logic [WIDTH-1:0]            jump_cst;
  logic                        jump_busy;

  lsd_jump_gen #(
    .WIDTH(WIDTH)
  ) u_jump_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (tap_wr),
    .tap      (tap_mask_r),
    .jump_coef(jump_coef),
    .jump_cst (jump_cst),
    .busy     (jump_busy)
  );

  // Recurrence state carried from item to item.
  logic [WIDTH-1:0] state_r;
  logic             msg_ok_r;

  // Output register plus one skid entry so in_stall never depends on out_stall.
  logic  out_valid_r;
  byte_t out_plain_r;
  logic  out_bok_r;
  logic  out_mok_r;
  logic  skid_valid_r;
  byte_t skid_plain_r;
  logic  skid_bok_r;
  logic  skid_mok_r;

  logic in_accept;
  logic out_fire;

  assign in_stall  = skid_valid_r | jump_busy;
  assign in_accept = in_valid & ~in_stall;
  assign out_fire  = out_valid_r & ~out_stall;

  // Per-item datapath: pick the starting state, apply the jump map, then pull the
  // key byte out of the top eight bits. The top bit after shift i ends up in bit i,
  // so key bit b comes from state bit WIDTH-1-b.
  logic [WIDTH-1:0] src_state;
  logic [WIDTH-1:0] new_state;
  byte_t            key_byte;
  byte_t            plain_byte;
  logic             byte_ok;
  logic             msg_ok_nxt;

  always_comb begin
    src_state = in_restart_message ? init_state_r : state_r;
    for (int k = 0; k < WIDTH; k++) begin
      new_state[k] = (^(jump_coef[k] & src_state)) ^ jump_cst[k];
    end
    for (int b = 0; b < BYTE_W; b++) begin
      key_byte[b] = new_state[WIDTH-1-b];
    end
    plain_byte = in_cipher_byte ^ key_byte;
    byte_ok    = is_printable(plain_byte);
    msg_ok_nxt = (in_restart_message | msg_ok_r) & byte_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= '0;
      msg_ok_r <= 1'b1;
    end else if (in_accept) begin
      state_r  <= new_state;
      msg_ok_r <= msg_ok_nxt;
    end
  end

  // Output stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output stage payload.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_plain_r <= skid_plain_r;
        out_bok_r   <= skid_bok_r;
        out_mok_r   <= skid_mok_r;
      end
    end else if (in_accept) begin
      if (out_valid_r && !out_fire) begin
        skid_plain_r <= plain_byte;
        skid_bok_r   <= byte_ok;
        skid_mok_r   <= msg_ok_nxt;
      end else begin
        out_plain_r <= plain_byte;
        out_bok_r   <= byte_ok;
        out_mok_r   <= msg_ok_nxt;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_plain_byte        = out_plain_r;
  assign out_byte_printable    = out_bok_r;
  assign out_message_printable = out_mok_r;

endmodule

FILE: design/lsd_checker.sv
// Port-level checker for the LFSR stream decryptor and its bind.
module lsd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input lsd_pkg::byte_t     out_plain_byte,
  input logic               cfg_we,
  input lsd_pkg::cfg_idx_t  cfg_index
);
  import lsd_pkg::*;

  // Reset always starts a jump map build, so no item may enter right after it.
  a_stall_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // A tap write starts a rebuild; the old map must not be used.
  a_stall_after_tap: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == REG_TAP_MASK)) |=> in_stall)
    else $error("input not stalled after tap write");

  // With an empty output stage an accepted item shows up in the next cycle.
  a_result_next_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> out_valid)
    else $error("accepted item produced no result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_plain_byte)))
    else $error("stalled result changed");

endmodule

bind lfsr_stream_decrypt lsd_checker u_lsd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_plain_byte(out_plain_byte),
  .cfg_we        (cfg_we),
  .cfg_index     (cfg_index)
);
